// ----- sv/npr_pkg.sv -----
// ----------------------------------------------------------------------------
// npr_pkg
// shared types and constants of the nearest position request scheduler
// ----------------------------------------------------------------------------
`default_nettype none

package npr_pkg;

  localparam int QUEUE_DEPTH_DEF   = 16;
  localparam int POSITION_BITS_DEF = 48;
  localparam int TAG_BITS_DEF      = 8;

  localparam logic MODE_ADD      = 1'b0;
  localparam logic MODE_DISPATCH = 1'b1;

  typedef enum logic [1:0] {
    STATUS_ADDED      = 2'd0,
    STATUS_DISPATCHED = 2'd1,
    STATUS_EMPTY      = 2'd2,
    STATUS_FULL       = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COPY,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic clear;
    logic sample;
  } cmp_ctl_t;

endpackage

`default_nettype wire

// ----- sv/npr_req_if.sv -----
// ----------------------------------------------------------------------------
// npr_req_if
// request channel: add or dispatch beats with valid and ready
// ----------------------------------------------------------------------------
`default_nettype none

interface npr_req_if #(
  parameter int POSITION_BITS = 48,
  parameter int TAG_BITS      = 8
);
  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic [POSITION_BITS-1:0] request_position;
  logic                     request_write;
  logic [TAG_BITS-1:0]      request_tag;

  modport source (
    output valid, mode, request_position, request_write, request_tag,
    input  ready
  );

  modport sink (
    input  valid, mode, request_position, request_write, request_tag,
    output ready
  );
endinterface

`default_nettype wire

// ----- sv/npr_rsp_if.sv -----
// ----------------------------------------------------------------------------
// npr_rsp_if
// result channel: one result beat per request beat
// ----------------------------------------------------------------------------
`default_nettype none

interface npr_rsp_if #(
  parameter int POSITION_BITS = 48,
  parameter int TAG_BITS      = 8,
  parameter int COUNT_BITS    = 5
);
  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic [POSITION_BITS-1:0] out_position;
  logic                     out_write;
  logic [TAG_BITS-1:0]      out_tag;
  logic [COUNT_BITS-1:0]    pending_count;

  modport source (
    output valid, status, out_position, out_write, out_tag, pending_count,
    input  ready
  );

  modport sink (
    input  valid, status, out_position, out_write, out_tag, pending_count,
    output ready
  );
endinterface

`default_nettype wire

// ----- sv/nearest_position_request_scheduler.sv -----
// ----------------------------------------------------------------------------
// nearest_position_request_scheduler
// shortest seek first scheduler over a queue of pending requests in ram
// ----------------------------------------------------------------------------
// channel  dir  handshake      payload
// req      in   valid / ready  mode, request_position, request_write, request_tag
// rsp      out  valid / ready  status, out_position, out_write, out_tag, pending_count
//
// an add or a refused beat goes through accept, then result load
// a dispatch scans every pending entry through the one distance comparator,
// closes up the ram behind the chosen slot k, then loads the result; one ram
// read per cycle paces the scan and the copy
// req.ready is high only in idle; a stalled rsp holds the finished result and
// the block waits in the result state until the output register frees
// synchronous active high reset clears control state; the ram needs no clearing
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_position_request_scheduler
  import npr_pkg::*;
#(
  parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF,
  parameter int TAG_BITS      = TAG_BITS_DEF,
  localparam int IDX_W  = $clog2(QUEUE_DEPTH),
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1),
  localparam int DATA_W = TAG_BITS + 1,
  localparam int WORD_W = POSITION_BITS + DATA_W
) (
  input wire logic clk,
  input wire logic rst,
  npr_req_if.sink  req,
  npr_rsp_if.source rsp
);

  state_t state;
  state_t state_next;

  logic [CNT_W-1:0]         count;
  logic [POSITION_BITS-1:0] head;
  logic [CNT_W-1:0]         scan_addr;
  logic                     rd_pend;
  logic [IDX_W-1:0]         rd_idx;
  logic [CNT_W-1:0]         copy_addr;
  logic                     copy_pend;
  logic [IDX_W-1:0]         copy_dst;
  status_t                  res_status;

  logic                     out_valid;
  status_t                  out_status;
  logic [POSITION_BITS-1:0] out_pos;
  logic                     out_wr;
  logic [TAG_BITS-1:0]      out_tg;
  logic [CNT_W-1:0]         out_cnt;

  logic                     accept;
  logic                     full;
  logic                     scan_rd;
  logic                     copy_rd;
  logic                     out_load;
  logic                     ram_we;
  logic [IDX_W-1:0]         ram_waddr;
  logic [WORD_W-1:0]        ram_wdata;
  logic                     ram_re;
  logic [IDX_W-1:0]         ram_raddr;
  logic [WORD_W-1:0]        ram_rdata;
  cmp_ctl_t                 cmp_ctl;

  logic [IDX_W-1:0]         best_idx;
  logic [POSITION_BITS-1:0] best_pos;
  logic [DATA_W-1:0]        best_data;

  npr_ram #(
    .WIDTH (WORD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  npr_nearest #(
    .POS_W  (POSITION_BITS),
    .IDX_W  (IDX_W),
    .DATA_W (DATA_W)
  ) u_nearest (
    .clk       (clk),
    .ctl       (cmp_ctl),
    .head      (head),
    .cand_pos  (ram_rdata[WORD_W-1:DATA_W]),
    .cand_data (ram_rdata[DATA_W-1:0]),
    .cand_idx  (rd_idx),
    .best_idx  (best_idx),
    .best_pos  (best_pos),
    .best_data (best_data)
  );

  // control outputs
  always_comb begin
    full      = (count == CNT_W'(QUEUE_DEPTH));
    accept    = 1'b0;
    scan_rd   = 1'b0;
    copy_rd   = 1'b0;
    out_load  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = count[IDX_W-1:0];
    ram_wdata = {req.request_position, req.request_write, req.request_tag};
    ram_re    = 1'b0;
    ram_raddr = scan_addr[IDX_W-1:0];
    cmp_ctl   = '{clear: 1'b0, sample: 1'b0};
    req.ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        accept    = req.valid;
        ram_we    = req.valid && (req.mode == MODE_ADD) && !full;
        cmp_ctl.clear = req.valid && (req.mode == MODE_DISPATCH);
      end
      ST_SCAN: begin
        scan_rd   = (scan_addr < count);
        ram_re    = scan_rd;
        cmp_ctl.sample = rd_pend;
      end
      ST_COPY: begin
        copy_rd   = (copy_addr < count);
        ram_re    = copy_rd;
        ram_raddr = copy_addr[IDX_W-1:0];
        ram_we    = copy_pend;
        ram_waddr = copy_dst;
        ram_wdata = ram_rdata;
      end
      ST_FINISH: begin
        out_load  = !out_valid || rsp.ready;
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (req.mode == MODE_DISPATCH && count != '0) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_SCAN: begin
        if (!scan_rd && !rd_pend) begin
          state_next = ST_COPY;
        end
      end
      ST_COPY: begin
        if (!copy_rd && !copy_pend) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      head      <= '0;
      rd_pend   <= 1'b0;
      copy_pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          rd_pend   <= 1'b0;
          copy_pend <= 1'b0;
          if (accept) begin
            scan_addr <= '0;
            if (req.mode == MODE_ADD) begin
              if (full) begin
                res_status <= STATUS_FULL;
              end else begin
                res_status <= STATUS_ADDED;
                count      <= count + CNT_W'(1);
              end
            end else if (count == '0) begin
              res_status <= STATUS_EMPTY;
            end
          end
        end
        ST_SCAN: begin
          rd_pend <= scan_rd;
          rd_idx  <= scan_addr[IDX_W-1:0];
          if (scan_rd) begin
            scan_addr <= scan_addr + CNT_W'(1);
          end
          copy_addr <= CNT_W'(best_idx) + CNT_W'(1);
        end
        ST_COPY: begin
          copy_pend <= copy_rd;
          copy_dst  <= IDX_W'(copy_addr - CNT_W'(1));
          if (copy_rd) begin
            copy_addr <= copy_addr + CNT_W'(1);
          end
          if (!copy_rd && !copy_pend) begin
            count      <= count - CNT_W'(1);
            head       <= best_pos;
            res_status <= STATUS_DISPATCHED;
          end
        end
        ST_FINISH: begin
        end
        default: begin
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status <= res_status;
      out_cnt    <= count;
      if (res_status == STATUS_DISPATCHED) begin
        out_pos <= best_pos;
        out_wr  <= best_data[DATA_W-1];
        out_tg  <= best_data[TAG_BITS-1:0];
      end else begin
        out_pos <= '0;
        out_wr  <= 1'b0;
        out_tg  <= '0;
      end
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.out_position  = out_pos;
  assign rsp.out_write     = out_wr;
  assign rsp.out_tag       = out_tg;
  assign rsp.pending_count = out_cnt;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("pending count above queue depth");

  a_dispatch_dec: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COPY && state_next == ST_FINISH) |=> count == $past(count) - CNT_W'(1))
    else $error("dispatch did not remove exactly one entry");

  a_no_scan_write: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_IDLE || state == ST_COPY))
    else $error("ram written outside add or compaction");

  a_copy_range: assert property (@(posedge clk) disable iff (rst)
    (ram_we && state == ST_COPY) |-> CNT_W'(copy_dst) < count - CNT_W'(1))
    else $error("compaction write beyond pending entries");

endmodule

`default_nettype wire

// ----- sv/npr_ram.sv -----
// ----------------------------------------------------------------------------
// npr_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module npr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- sv/npr_nearest.sv -----
// ----------------------------------------------------------------------------
// npr_nearest
// shared distance compare unit, keeps the nearest candidate seen so far
// ----------------------------------------------------------------------------
`default_nettype none

module npr_nearest
  import npr_pkg::*;
#(
  parameter int POS_W  = 48,
  parameter int IDX_W  = 4,
  parameter int DATA_W = 9
) (
  input  wire logic              clk,
  input  wire cmp_ctl_t          ctl,
  input  wire logic [POS_W-1:0]  head,
  input  wire logic [POS_W-1:0]  cand_pos,
  input  wire logic [DATA_W-1:0] cand_data,
  input  wire logic [IDX_W-1:0]  cand_idx,
  output logic      [IDX_W-1:0]  best_idx,
  output logic      [POS_W-1:0]  best_pos,
  output logic      [DATA_W-1:0] best_data
);

  logic             first;
  logic [POS_W-1:0] best_dist;
  logic [POS_W-1:0] cand_dist;
  logic             take;

  always_comb begin
    cand_dist = (cand_pos >= head) ? (cand_pos - head) : (head - cand_pos);
    // strict less keeps the oldest on a tie
    take = first || (cand_dist < best_dist);
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      first <= 1'b1;
    end else if (ctl.sample) begin
      first <= 1'b0;
      if (take) begin
        best_dist <= cand_dist;
        best_idx  <= cand_idx;
        best_pos  <= cand_pos;
        best_data <= cand_data;
      end
    end
  end

endmodule

`default_nettype wire

// ----- tb/tb_nearest_position_request_scheduler.sv -----
// ----------------------------------------------------------------------------
// tb_nearest_position_request_scheduler
// self-checking bench for the shortest seek first request scheduler
// ----------------------------------------------------------------------------
// a scoreboard keeps its own copy of the pending queue and the head position,
// predicts the result of every accepted request beat and compares each result
// beat with the oldest prediction. a short directed part covers empty and full
// queues, the extreme positions and equal distances; random traffic follows,
// with bursty requests, ties aimed at the head, and a result side that stalls,
// twice for long enough to back the block up
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_nearest_position_request_scheduler
  import npr_pkg::*;
;

  localparam int DEPTH       = QUEUE_DEPTH_DEF;
  localparam int POS_W       = POSITION_BITS_DEF;
  localparam int TAG_W       = TAG_BITS_DEF;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int RANDOM_ITEMS = 1950;
  localparam int CYCLE_LIMIT  = 500000;

  typedef struct packed {
    status_t             status;
    logic [POS_W-1:0]    position;
    logic                write;
    logic [TAG_W-1:0]    tag;
    logic [CNT_W-1:0]    pending_count;
  } sched_result_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             write;
    logic [TAG_W-1:0] tag;
  } queued_req_t;

  class seek_scoreboard;
    queued_req_t      queued_reqs[$];
    logic [POS_W-1:0] head;
    sched_result_t    expected_results[$];
    int unsigned      failures;

    function new();
      head     = '0;
      failures = 0;
    endfunction

    function logic [POS_W-1:0] seek_distance(logic [POS_W-1:0] a, logic [POS_W-1:0] b);
      return (a >= b) ? a - b : b - a;
    endfunction

    function int outstanding();
      return expected_results.size();
    endfunction

    function void note_request(logic m, logic [POS_W-1:0] p, logic w, logic [TAG_W-1:0] t);
      sched_result_t    r;
      queued_req_t      q;
      int               best;
      logic [POS_W-1:0] best_dist;
      logic [POS_W-1:0] d;
      r.status   = STATUS_ADDED;
      r.position = '0;
      r.write    = 1'b0;
      r.tag      = '0;
      if (m == MODE_ADD) begin
        if (queued_reqs.size() >= DEPTH) begin
          r.status = STATUS_FULL;
        end else begin
          q.position = p;
          q.write    = w;
          q.tag      = t;
          queued_reqs.push_back(q);
        end
      end else if (queued_reqs.size() == 0) begin
        r.status = STATUS_EMPTY;
      end else begin
        best      = 0;
        best_dist = seek_distance(queued_reqs[0].position, head);
        for (int i = 1; i < queued_reqs.size(); i++) begin
          d = seek_distance(queued_reqs[i].position, head);
          if (d < best_dist) begin
            best_dist = d;
            best      = i;
          end
        end
        r.status   = STATUS_DISPATCHED;
        r.position = queued_reqs[best].position;
        r.write    = queued_reqs[best].write;
        r.tag      = queued_reqs[best].tag;
        queued_reqs.delete(best);
        head = r.position;
      end
      r.pending_count = CNT_W'(queued_reqs.size());
      expected_results.push_back(r);
    endfunction

    function void check_result(sched_result_t got);
      sched_result_t want;
      if (expected_results.size() == 0) begin
        $error("result beat with no request outstanding");
        failures++;
        return;
      end
      want = expected_results.pop_front();
      if (got.status !== want.status) begin
        $error("status expected %0d actual %0d", want.status, got.status);
        failures++;
      end
      if (got.position !== want.position) begin
        $error("out_position expected %0h actual %0h", want.position, got.position);
        failures++;
      end
      if (got.write !== want.write) begin
        $error("out_write expected %0d actual %0d", want.write, got.write);
        failures++;
      end
      if (got.tag !== want.tag) begin
        $error("out_tag expected %0d actual %0d", want.tag, got.tag);
        failures++;
      end
      if (got.pending_count !== want.pending_count) begin
        $error("pending_count expected %0d actual %0d", want.pending_count,
               got.pending_count);
        failures++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  npr_req_if #(.POSITION_BITS(POS_W), .TAG_BITS(TAG_W)) req_ch ();
  npr_rsp_if #(.POSITION_BITS(POS_W), .TAG_BITS(TAG_W), .COUNT_BITS(CNT_W)) rsp_ch ();

  nearest_position_request_scheduler #(
    .QUEUE_DEPTH   (DEPTH),
    .POSITION_BITS (POS_W),
    .TAG_BITS      (TAG_W)
  ) u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  seek_scoreboard sb = new();

  int unsigned cycle_count = 0;
  int          rsp_seen    = 0;
  int          next_hold_at = 400;
  int          hold_left   = 0;
  int          pat_left    = 0;
  int          pat_kind    = 0;

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side: stall patterns plus a long hold now and then
  always @(posedge clk) begin
    sched_result_t got;
    if (rsp_ch.valid && rsp_ch.ready) begin
      got.status        = status_t'(rsp_ch.status);
      got.position      = rsp_ch.out_position;
      got.write         = rsp_ch.out_write;
      got.tag           = rsp_ch.out_tag;
      got.pending_count = rsp_ch.pending_count;
      sb.check_result(got);
      rsp_seen = rsp_seen + 1;
    end
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      rsp_ch.ready <= 1'b0;
    end else if (rsp_seen >= next_hold_at) begin
      next_hold_at = next_hold_at + 900;
      hold_left    = 600;
      rsp_ch.ready <= 1'b0;
    end else begin
      if (pat_left == 0) begin
        pat_kind = $urandom_range(0, 3);
        pat_left = (pat_kind == 3) ? $urandom_range(1, 12) : $urandom_range(1, 60);
      end
      pat_left = pat_left - 1;
      case (pat_kind)
        0: rsp_ch.ready <= 1'b1;
        1: rsp_ch.ready <= 1'($urandom_range(0, 1));
        2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
        default: rsp_ch.ready <= 1'b0;
      endcase
    end
  end

  function automatic logic [POS_W-1:0] rand_position();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[POS_W-1:0];
  endfunction

  // positions near or at the head, mirrored around it for ties, the extremes, a cluster near 1000, or anywhere
  function automatic logic [POS_W-1:0] pick_position();
    logic [POS_W-1:0] delta;
    int               idx;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: return rand_position();
      4, 5: begin
        delta = POS_W'($urandom_range(0, 64));
        return sb.head + delta - POS_W'(32);
      end
      6, 7: return POS_W'(1000 + $urandom_range(0, 63));
      8: return sb.head;
      default: begin
        if (sb.queued_reqs.size() == 0) return rand_position();
        idx = $urandom_range(0, sb.queued_reqs.size() - 1);
        return (sb.head << 1) - sb.queued_reqs[idx].position;
      end
    endcase
  endfunction

  task automatic send_beat(input logic m, input logic [POS_W-1:0] p, input logic w,
                           input logic [TAG_W-1:0] t);
    req_ch.valid            <= 1'b1;
    req_ch.mode             <= m;
    req_ch.request_position <= p;
    req_ch.request_write    <= w;
    req_ch.request_tag      <= t;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sb.note_request(m, p, w, t);
  endtask

  task automatic idle_gap(input int n);
    if (n > 0) begin
      req_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  task automatic run_directed();
    send_beat(MODE_DISPATCH, '1, 1'b1, 8'hff);
    send_beat(MODE_ADD, POS_W'(100), 1'b0, 8'd1);
    send_beat(MODE_ADD, '0, 1'b0, 8'd0);
    send_beat(MODE_DISPATCH, '0, 1'b0, 8'd0);
    send_beat(MODE_ADD, '1, 1'b1, 8'hff);
    send_beat(MODE_DISPATCH, '0, 1'b0, 8'd0);
    // equal distance around the head, the older must win
    send_beat(MODE_ADD, POS_W'(110), 1'b1, 8'd3);
    idle_gap(3);
    send_beat(MODE_ADD, POS_W'(90), 1'b0, 8'd4);
    send_beat(MODE_DISPATCH, '0, 1'b0, 8'd0);
    for (int i = 0; i < 15; i++) begin
      send_beat(MODE_ADD, rand_position(), i[0], TAG_W'(16 + i));
    end
    send_beat(MODE_ADD, POS_W'(12345), 1'b1, 8'haa);
  endtask

  task automatic run_random(input int n_items);
    int   sent;
    int   burst;
    int   add_pct;
    bit   paused;
    logic m;
    sent   = 0;
    paused = 1'b0;
    while (sent < n_items) begin
      burst = $urandom_range(1, 40);
      case ($urandom_range(0, 5))
        0: add_pct = 95;
        1: add_pct = 10;
        default: add_pct = $urandom_range(30, 70);
      endcase
      for (int k = 0; k < burst && sent < n_items; k++) begin
        m = ($urandom_range(0, 99) < add_pct) ? MODE_ADD : MODE_DISPATCH;
        send_beat(m, pick_position(), 1'($urandom_range(0, 1)),
                  TAG_W'($urandom_range(0, 255)));
        sent++;
      end
      if (!paused && sent >= n_items / 2) begin
        paused = 1'b1;
        wait_drained();
      end else begin
        idle_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
      end
    end
  endtask

  initial begin
    rst                     <= 1'b1;
    req_ch.valid            <= 1'b0;
    req_ch.mode             <= MODE_ADD;
    req_ch.request_position <= '0;
    req_ch.request_write    <= 1'b0;
    req_ch.request_tag      <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    wait_drained();
    run_random(RANDOM_ITEMS);
    wait_drained();
    repeat (40) @(posedge clk);
    if (sb.failures == 0 && sb.outstanding() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/npr_pkg.sv
sv/npr_req_if.sv
sv/npr_rsp_if.sv
sv/npr_ram.sv
sv/npr_nearest.sv
sv/nearest_position_request_scheduler.sv
tb/tb_nearest_position_request_scheduler.sv
